// ----- hdl/qlu_pkg.sv -----
// Shared types, character codes and helpers for the quoted literal unescaper.
package qlu_pkg;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       has_char;
    logic       escape_error;
    logic       last;
  } out_word_t;

  // Up to three result words per input word, compacted from slot 0.
  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    logic [1:0]                 cnt;
    out_word_t [MaxResults-1:0] word;
  } scan_res_t;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChApos   = 8'h27;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChB      = 8'h62;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChF      = 8'h66;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChXLower = 8'h78;
  localparam logic [7:0] ChXUpper = 8'h58;
  localparam logic [7:0] Ch0      = 8'h30;
  localparam logic [7:0] Ch9      = 8'h39;
  localparam logic [7:0] ChAUpper = 8'h41;
  localparam logic [7:0] ChFUpper = 8'h46;
  localparam logic [7:0] ChALower = 8'h61;
  localparam logic [7:0] ChFLower = 8'h66;

  localparam logic [7:0] CtlBs = 8'h08;
  localparam logic [7:0] CtlHt = 8'h09;
  localparam logic [7:0] CtlLf = 8'h0A;
  localparam logic [7:0] CtlFf = 8'h0C;
  localparam logic [7:0] CtlCr = 8'h0D;

  localparam logic [15:0] HexLimit = 16'd127;

  // Bit 4: byte is a hex digit; bits 3:0: its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= Ch0 && c <= Ch9) begin
      r = {1'b1, 4'(c - Ch0)};
    end else if (c >= ChAUpper && c <= ChFUpper) begin
      r = {1'b1, 4'(c - ChAUpper + 8'hA)};
    end else if (c >= ChALower && c <= ChFLower) begin
      r = {1'b1, 4'(c - ChALower + 8'hA)};
    end
    return r;
  endfunction

endpackage

// ----- hdl/quoted_literal_unescaper_core.sv -----
// Top level of the quoted string literal unescaper.
//
// Input channel (in_valid_i/in_ready_o/in_word_i): one raw literal byte per word,
// with end_of_text marking the final byte. Bytes outside double quotes are
// dropped; escapes inside quotes (\b \t \n \f \r \" \' \\ and \x/\X with up to
// MaxHexDigits hex digits) are decoded. Unknown escapes are dropped; hex values
// above 127 give a word with escape_error set instead of a byte.
// Output channel (out_valid_o/out_ready_i/out_word_o): decoded words. An input
// word with end_of_text yields a final word with last set.
// Each result is decoded combinationally and queued when its word is accepted.
// Throughput: one input word per cycle while each yields at most one result and
// the output is not stalled; an input word yields up to three results and the
// output drains at most one per cycle, so the rate is set by the output port and
// the four-entry result queue (input ready while at most one result is queued).
// Reset clears the scan state to outside quotes and empties the queue.
// A stalled receiver fills the queue and then deasserts in_ready_o; scan state
// advances only on accepted words.
module quoted_literal_unescaper_core #(
  parameter int unsigned MaxHexDigits = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  qlu_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output qlu_pkg::out_word_t out_word_o
);

  logic               accept;
  logic               space;
  qlu_pkg::scan_res_t res;

  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  qlu_scanner #(
    .MaxHexDigits(MaxHexDigits)
  ) u_scanner (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_word_i(in_word_i),
    .res_o    (res)
  );

  qlu_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .res_i      (res),
    .space_o    (space),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

endmodule

// ----- hdl/qlu_scanner.sv -----
// Scan state and per-word escape decode; produces up to three result words.
module qlu_scanner #(
  parameter int unsigned MaxHexDigits = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  qlu_pkg::in_word_t   in_word_i,
  output qlu_pkg::scan_res_t  res_o
);

  localparam int unsigned AccW = 4 * MaxHexDigits;
  localparam int unsigned CntW = $clog2(MaxHexDigits + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxHexDigits);

  localparam logic [1:0] ModeOutside = 2'd0;
  localparam logic [1:0] ModeText    = 2'd1;
  localparam logic [1:0] ModeEscape  = 2'd2;
  localparam logic [1:0] ModeHex     = 2'd3;

  logic [1:0]      mode_q, mode_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [7:0]      c;
  logic [4:0]      hv;
  logic [AccW-1:0] acc_sh;
  logic [CntW-1:0] cnt_inc;
  logic            a_en, b_en, c_en, text_en;
  logic [7:0]      b_char;
  logic [AccW-1:0] fin_acc;
  logic [CntW-1:0] fin_cnt;
  logic [15:0]     fin_ext;
  logic            a_valid, a_err;
  qlu_pkg::out_word_t a_word, b_word, c_word;

  always_comb begin
    c       = in_word_i.char_in;
    hv      = qlu_pkg::hex_digit(c);
    acc_sh  = AccW'({acc_q, hv[3:0]});
    cnt_inc = cnt_q + 1'b1;
    mode_d  = mode_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    a_en    = 1'b0;
    b_en    = 1'b0;
    c_en    = 1'b0;
    text_en = 1'b0;
    b_char  = c;
    fin_acc = acc_q;
    fin_cnt = cnt_q;

    unique case (mode_q)
      ModeOutside: begin
        if (c == qlu_pkg::ChQuote) mode_d = ModeText;
      end
      ModeText: begin
        text_en = 1'b1;
      end
      ModeEscape: begin
        mode_d = ModeText;
        unique case (c)
          qlu_pkg::ChB: begin
            b_en = 1'b1; b_char = qlu_pkg::CtlBs;
          end
          qlu_pkg::ChT: begin
            b_en = 1'b1; b_char = qlu_pkg::CtlHt;
          end
          qlu_pkg::ChN: begin
            b_en = 1'b1; b_char = qlu_pkg::CtlLf;
          end
          qlu_pkg::ChF: begin
            b_en = 1'b1; b_char = qlu_pkg::CtlFf;
          end
          qlu_pkg::ChR: begin
            b_en = 1'b1; b_char = qlu_pkg::CtlCr;
          end
          qlu_pkg::ChQuote, qlu_pkg::ChApos, qlu_pkg::ChBslash: begin
            b_en = 1'b1;
          end
          qlu_pkg::ChXLower, qlu_pkg::ChXUpper: begin
            mode_d = ModeHex;
            acc_d  = '0;
            cnt_d  = '0;
          end
          default: ;
        endcase
      end
      ModeHex: begin
        if (hv[4] && cnt_q < CntMax) begin
          if (cnt_inc == CntMax) begin
            a_en    = 1'b1;
            fin_acc = acc_sh;
            fin_cnt = cnt_inc;
            acc_d   = '0;
            cnt_d   = '0;
            mode_d  = ModeText;
          end else begin
            acc_d = acc_sh;
            cnt_d = cnt_inc;
          end
        end else begin
          a_en    = 1'b1;
          acc_d   = '0;
          cnt_d   = '0;
          mode_d  = ModeText;
          text_en = 1'b1;
        end
      end
    endcase

    if (text_en) begin
      if (c == qlu_pkg::ChBslash) begin
        mode_d = ModeEscape;
      end else if (c == qlu_pkg::ChQuote) begin
        mode_d = ModeOutside;
      end else begin
        b_en = 1'b1;
      end
    end

    if (in_word_i.end_of_text) begin
      if (mode_d == ModeHex) begin
        a_en    = 1'b1;
        fin_acc = acc_d;
        fin_cnt = cnt_d;
      end
      c_en   = 1'b1;
      mode_d = ModeOutside;
      acc_d  = '0;
      cnt_d  = '0;
    end

    fin_ext = 16'(fin_acc);
    a_valid = a_en && (fin_cnt != '0);
    a_err   = fin_ext > qlu_pkg::HexLimit;

    a_word              = '0;
    a_word.char_out     = a_err ? 8'h00 : 8'(fin_acc);
    a_word.has_char     = !a_err;
    a_word.escape_error = a_err;
    b_word              = '0;
    b_word.char_out     = b_char;
    b_word.has_char     = 1'b1;
    c_word              = '0;
    c_word.last         = 1'b1;

    res_o = '0;
    if (a_valid) begin
      res_o.word[res_o.cnt] = a_word;
      res_o.cnt             = res_o.cnt + 2'd1;
    end
    if (b_en) begin
      res_o.word[res_o.cnt] = b_word;
      res_o.cnt             = res_o.cnt + 2'd1;
    end
    if (c_en) begin
      res_o.word[res_o.cnt] = c_word;
      res_o.cnt             = res_o.cnt + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeOutside;
      acc_q  <= '0;
      cnt_q  <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && in_word_i.end_of_text |=> mode_q == ModeOutside && cnt_q == '0)
    else $error("scan state not cleared after end of text");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CntMax)
    else $error("hex digit count reached limit without completing");
  a_cnt_only_hex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != ModeHex |-> cnt_q == '0)
    else $error("hex digit count nonzero outside hex mode");
`endif

endmodule

// ----- hdl/qlu_result_fifo.sv -----
// Four-entry queue: takes up to three words per cycle, drains at most one.
module qlu_result_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  qlu_pkg::scan_res_t  res_i,
  output logic                space_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output qlu_pkg::out_word_t  out_word_o
);

  localparam int unsigned Depth = 4;

  qlu_pkg::out_word_t mem_q [Depth];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;
  logic [1:0] push_cnt;
  logic       pop;

  assign push_cnt    = push_i ? res_i.cnt : 2'd0;
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = count_q != 3'd0;
  assign out_word_o  = mem_q[rd_ptr_q];
  assign space_o     = count_q <= 3'(Depth - qlu_pkg::MaxResults);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < qlu_pkg::MaxResults; i++) begin
      if (2'(i) < push_cnt) begin
        mem_q[wr_ptr_q + 2'(i)] <= res_i.word[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_cnt;
      rd_ptr_q <= rd_ptr_q + 2'(pop);
      count_q  <= count_q + 3'(push_cnt) - 3'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'(Depth))
    else $error("result queue overflow");
  a_push_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> space_o)
    else $error("push without room for three words");
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_cnt == 2'd0 && !pop |=> $stable(count_q))
    else $error("queue count moved without push or pop");
`endif

endmodule

// ----- tb/sv/quoted_literal_unescaper_check.sv -----
`timescale 1ns / 1ps
// Scoreboard for the unescaper: predicts decoded words from accepted input words and checks them.
module quoted_literal_unescaper_check #(
  parameter int unsigned MaxHexDigits = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  qlu_pkg::in_word_t  in_word_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  qlu_pkg::out_word_t out_word_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef enum logic [1:0] {ScanOutside, ScanText, ScanEscape, ScanHex} scan_mode_e;

  scan_mode_e         mode = ScanOutside;
  logic [15:0]        hex_val = '0;
  logic [2:0]         hex_digits = '0;
  qlu_pkg::out_word_t decoded_q[$];
  int                 mismatches = 0;
  int                 pending_cnt = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending_cnt;

  function automatic void push_word(logic [7:0] c, logic has, logic err, logic fin);
    qlu_pkg::out_word_t w;
    w.char_out     = c;
    w.has_char     = has;
    w.escape_error = err;
    w.last         = fin;
    decoded_q.push_back(w);
  endfunction

  function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
    logic hit;
    hit = 1'b1;
    v   = '0;
    if (c >= qlu_pkg::Ch0 && c <= qlu_pkg::Ch9) begin
      v = 4'(c - qlu_pkg::Ch0);
    end else if (c >= qlu_pkg::ChAUpper && c <= qlu_pkg::ChFUpper) begin
      v = 4'(c - qlu_pkg::ChAUpper + 8'd10);
    end else if (c >= qlu_pkg::ChALower && c <= qlu_pkg::ChFLower) begin
      v = 4'(c - qlu_pkg::ChALower + 8'd10);
    end else begin
      hit = 1'b0;
    end
    return hit;
  endfunction

  function automatic void close_hex();
    if (hex_digits != 0) begin
      if (hex_val > qlu_pkg::HexLimit) begin
        push_word(8'h00, 1'b0, 1'b1, 1'b0);
      end else begin
        push_word(hex_val[7:0], 1'b1, 1'b0, 1'b0);
      end
    end
    hex_val    = '0;
    hex_digits = '0;
    mode       = ScanText;
  endfunction

  function automatic void text_char(logic [7:0] c);
    if (c == qlu_pkg::ChBslash) begin
      mode = ScanEscape;
    end else if (c == qlu_pkg::ChQuote) begin
      mode = ScanOutside;
    end else begin
      push_word(c, 1'b1, 1'b0, 1'b0);
    end
  endfunction

  function automatic void decode_word(qlu_pkg::in_word_t w);
    logic [3:0] nib;
    logic       is_hex;
    case (mode)
      ScanOutside: begin
        if (w.char_in == qlu_pkg::ChQuote) mode = ScanText;
      end
      ScanText: text_char(w.char_in);
      ScanEscape: begin
        mode = ScanText;
        case (w.char_in)
          qlu_pkg::ChB: push_word(qlu_pkg::CtlBs, 1'b1, 1'b0, 1'b0);
          qlu_pkg::ChT: push_word(qlu_pkg::CtlHt, 1'b1, 1'b0, 1'b0);
          qlu_pkg::ChN: push_word(qlu_pkg::CtlLf, 1'b1, 1'b0, 1'b0);
          qlu_pkg::ChF: push_word(qlu_pkg::CtlFf, 1'b1, 1'b0, 1'b0);
          qlu_pkg::ChR: push_word(qlu_pkg::CtlCr, 1'b1, 1'b0, 1'b0);
          qlu_pkg::ChQuote, qlu_pkg::ChApos, qlu_pkg::ChBslash:
            push_word(w.char_in, 1'b1, 1'b0, 1'b0);
          qlu_pkg::ChXLower, qlu_pkg::ChXUpper: begin
            mode       = ScanHex;
            hex_val    = '0;
            hex_digits = '0;
          end
          default: ;
        endcase
      end
      default: begin
        is_hex = hex_nibble(w.char_in, nib);
        if (is_hex && hex_digits < MaxHexDigits) begin
          hex_val    = {hex_val[11:0], nib};
          hex_digits = hex_digits + 3'd1;
          if (hex_digits >= MaxHexDigits) close_hex();
        end else begin
          close_hex();
          text_char(w.char_in);
        end
      end
    endcase
    if (w.end_of_text) begin
      if (mode == ScanHex) close_hex();
      push_word(8'h00, 1'b0, 1'b0, 1'b1);
      mode       = ScanOutside;
      hex_val    = '0;
      hex_digits = '0;
    end
  endfunction

  function automatic void check_word(qlu_pkg::out_word_t got);
    qlu_pkg::out_word_t want;
    if (decoded_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: unexpected word: char %02h has %b err %b last %b", $time,
                 got.char_out, got.has_char, got.escape_error, got.last);
      end
    end else begin
      want = decoded_q.pop_front();
      if (got.char_out !== want.char_out || got.has_char !== want.has_char ||
          got.escape_error !== want.escape_error || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: word mismatch: expected char %02h has %b err %b last %b",
                   $time, want.char_out, want.has_char, want.escape_error, want.last);
          $display("%0t:                got      char %02h has %b err %b last %b",
                   $time, got.char_out, got.has_char, got.escape_error, got.last);
        end
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode       = ScanOutside;
      hex_val    = '0;
      hex_digits = '0;
      decoded_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_word(out_word_i);
      if (in_valid_i && in_ready_i) decode_word(in_word_i);
    end
    pending_cnt = decoded_q.size();
  end

endmodule

// ----- tb/sv/quoted_literal_unescaper_core_test.sv -----
`timescale 1ns / 1ps
// Top of the unescaper testbench: clock, reset, literal stimulus, output stalls and verdict.
module quoted_literal_unescaper_core_test;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  qlu_pkg::in_word_t  in_word_i;
  logic               out_valid_o;
  logic               out_ready_i;
  qlu_pkg::out_word_t out_word_o;

  int          fail_count;
  int          pending;
  bit          calm;
  int unsigned words_sent;
  logic [7:0]  lit_q[$];

  quoted_literal_unescaper_core #(.MaxHexDigits(4)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  quoted_literal_unescaper_check #(.MaxHexDigits(4)) u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_word_i    (in_word_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_i   (out_word_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (calm) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= 12);
    end
  end

  task automatic put_byte(input logic [7:0] c, input bit eot);
    if (!calm && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= '{char_in: c, end_of_text: eot};
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  task automatic send_text(input string s, input bit eot_at_end);
    for (int i = 0; i < s.len(); i++) begin
      put_byte(8'(s[i]), eot_at_end && (i == s.len() - 1));
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] hex_char(input bit low_digit);
    logic [3:0] v;
    v = low_digit ? 4'($urandom_range(7)) : 4'($urandom_range(15));
    if (v < 10) return 8'(qlu_pkg::Ch0 + v);
    return $urandom_range(1) ? 8'(qlu_pkg::ChALower + v - 10)
                             : 8'(qlu_pkg::ChAUpper + v - 10);
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(32, 126));
    if (c == qlu_pkg::ChQuote || c == qlu_pkg::ChBslash) c = qlu_pkg::ChALower;
    return c;
  endfunction

  function automatic logic [7:0] simple_escape();
    logic [7:0] c;
    case ($urandom_range(7))
      0:       c = qlu_pkg::ChB;
      1:       c = qlu_pkg::ChT;
      2:       c = qlu_pkg::ChN;
      3:       c = qlu_pkg::ChF;
      4:       c = qlu_pkg::ChR;
      5:       c = qlu_pkg::ChQuote;
      6:       c = qlu_pkg::ChApos;
      default: c = qlu_pkg::ChBslash;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] outside_char();
    logic [7:0] c;
    case ($urandom_range(3))
      0:       c = 8'h20;
      1:       c = qlu_pkg::CtlLf;
      2:       c = qlu_pkg::CtlHt;
      default: c = 8'($urandom_range(255));
    endcase
    if (c == qlu_pkg::ChQuote) c = 8'h20;
    return c;
  endfunction

  function automatic void add_token();
    int         digits;
    bit         small_val;
    logic [7:0] c;
    case ($urandom_range(9))
      0, 1, 2: lit_q.push_back(plain_char());
      3: begin
        c = 8'($urandom_range(255));
        if (c == qlu_pkg::ChQuote || c == qlu_pkg::ChBslash) c = 8'hFF;
        lit_q.push_back(c);
      end
      4, 5: begin
        lit_q.push_back(qlu_pkg::ChBslash);
        lit_q.push_back(simple_escape());
      end
      6: begin
        lit_q.push_back(qlu_pkg::ChBslash);
        lit_q.push_back(plain_char());
      end
      default: begin
        digits    = $urandom_range(0, 5);
        small_val = $urandom_range(1);
        lit_q.push_back(qlu_pkg::ChBslash);
        lit_q.push_back($urandom_range(1) ? qlu_pkg::ChXLower : qlu_pkg::ChXUpper);
        for (int d = 0; d < digits; d++) begin
          if (small_val && d < digits - 2) begin
            lit_q.push_back(qlu_pkg::Ch0);
          end else begin
            lit_q.push_back(hex_char(small_val && d == digits - 2));
          end
        end
      end
    endcase
  endfunction

  // One literal: adjacent segments with outside filler, or now and then raw junk.
  function automatic void build_literal();
    int segs;
    int toks;
    lit_q.delete();
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(3))
          0:       lit_q.push_back(qlu_pkg::ChQuote);
          1:       lit_q.push_back(qlu_pkg::ChBslash);
          default: lit_q.push_back(8'($urandom_range(255)));
        endcase
      end
      return;
    end
    segs = $urandom_range(1, 3);
    for (int sg = 0; sg < segs; sg++) begin
      repeat ($urandom_range(0, 2)) lit_q.push_back(outside_char());
      lit_q.push_back(qlu_pkg::ChQuote);
      toks = $urandom_range(0, 6);
      for (int t = 0; t < toks; t++) add_token();
      if ($urandom_range(99) < 88) lit_q.push_back(qlu_pkg::ChQuote);
    end
  endfunction

  initial begin
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    rst_ni      = 1'b0;
    calm        = 1'b0;
    words_sent  = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all simple escapes, byte extremes inside and outside quotes
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b0);
    send_text("\"", 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);
    send_text("\\b\\t\\n\\f\\r\\\"\\'\\\\\"", 1'b1);
    // hex ended by text, full-length hex over the limit, unknown escape,
    // hex without digits, end inside hex
    send_text("\"\\x7fZ\\X0080\\zq\\xg\\x1", 1'b1);
    send_text("\"a\\", 1'b1);
    send_text(" \"\\xFFF", 1'b1);
    put_byte(8'hFF, 1'b1);
    wait_drained();

    for (int lit = 0; words_sent < 460; lit++) begin
      calm <= (lit >= 6 && lit < 13);
      build_literal();
      foreach (lit_q[i]) put_byte(lit_q[i], i == lit_q.size() - 1);
      if (lit == 12) wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
